[src/iris_wipe_transition_top_defines.svh]
// Assertion macros shared by the iris wipe transition top level.
`ifndef IRIS_WIPE_TRANSITION_TOP_DEFINES_SVH
`define IRIS_WIPE_TRANSITION_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define IWT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define IWT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/iwt_pkg.sv]
// Types and constants shared by the iris wipe transition modules.
package iwt_pkg;

	// request kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_LOAD  = 2'd2;
	localparam logic [1:0] KIND_PIXEL = 2'd3;

	// transition phases
	localparam logic [1:0] PH_CLOSE = 2'd0;
	localparam logic [1:0] PH_HOLD  = 2'd1;
	localparam logic [1:0] PH_OPEN  = 2'd2;

	// register indexes (byte address 4*i)
	localparam int          APB_AW       = 5;
	localparam logic [2:0]  REG_CLOSE    = 3'd0;
	localparam logic [2:0]  REG_HOLD     = 3'd1;
	localparam logic [2:0]  REG_OPEN     = 3'd2;
	localparam logic [2:0]  REG_LEVELS   = 3'd3;
	localparam logic [2:0]  REG_WIDTH    = 3'd4;
	localparam logic [2:0]  REG_HEIGHT   = 3'd5;

	// register reset values
	localparam logic [15:0] CLOSE_RST  = 16'd450;
	localparam logic [15:0] HOLD_RST   = 16'd100;
	localparam logic [15:0] OPEN_RST   = 16'd450;
	localparam logic [7:0]  LEVELS_RST = 8'd5;
	localparam logic [10:0] WIDTH_RST  = 11'd640;
	localparam logic [10:0] HEIGHT_RST = 11'd480;

	// radius thresholds, Q16
	localparam logic [16:0] RADIUS_FULL  = 17'd65536;
	localparam logic [16:0] RADIUS_PASS  = 17'd65530;
	localparam logic [16:0] RADIUS_BLACK = 17'd6;
	localparam logic [31:0] BLACK_ARGB   = 32'hFF000000;

	// radius divider: one quotient bit per cycle
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  delta_ms;
		logic [7:0]  level_index;
		logic        reset_player;
		logic        load_ok;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [31:0] pixel_color;
	} in_t;

	typedef struct packed {
		logic [31:0] pixel_out;
		logic        load_request;
		logic [7:0]  load_level;
		logic        load_full_reset;
		logic        busy_res;
		logic [1:0]  cur_phase;
		logic [16:0] cur_radius;
	} out_t;

	typedef struct packed {
		logic [15:0] close_ms;
		logic [15:0] hold_ms;
		logic [15:0] open_ms;
		logic [7:0]  num_levels;
		logic [10:0] frame_width;
		logic [10:0] frame_height;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic div_step;
		logic ref_clr;
		logic ref_sq;
		logic ref_diag;
		logic ref_lo;
		logic ref_hi;
		logic ref_sum;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic need_ref;
		logic div_last;
	} sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_REF_SQ,
		ST_REF_DIAG,
		ST_REF_LO,
		ST_REF_HI,
		ST_REF_SUM,
		ST_EMIT
	} ctrl_state_t;

endpackage

[src/iwt_regs.sv]
// APB configuration registers of the iris wipe transition.
module iwt_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [iwt_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        ref_clr,
	output iwt_pkg::cfg_t               cfg,
	output logic                        ref_pend
);

	iwt_pkg::cfg_t cfg_q;
	logic          ref_pend_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;

	// write registers, mask to field widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.close_ms     <= iwt_pkg::CLOSE_RST;
			cfg_q.hold_ms      <= iwt_pkg::HOLD_RST;
			cfg_q.open_ms      <= iwt_pkg::OPEN_RST;
			cfg_q.num_levels   <= iwt_pkg::LEVELS_RST;
			cfg_q.frame_width  <= iwt_pkg::WIDTH_RST;
			cfg_q.frame_height <= iwt_pkg::HEIGHT_RST;
		end else if (wr_en) begin
			case (idx)
				iwt_pkg::REG_CLOSE:  cfg_q.close_ms     <= pwdata[15:0];
				iwt_pkg::REG_HOLD:   cfg_q.hold_ms      <= pwdata[15:0];
				iwt_pkg::REG_OPEN:   cfg_q.open_ms      <= pwdata[15:0];
				iwt_pkg::REG_LEVELS: cfg_q.num_levels   <= pwdata[7:0];
				iwt_pkg::REG_WIDTH:  cfg_q.frame_width  <= pwdata[10:0];
				iwt_pkg::REG_HEIGHT: cfg_q.frame_height <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// flag a limit refresh when the frame size changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_pend_q <= 1'b0;
		end else if (wr_en && (idx == iwt_pkg::REG_WIDTH || idx == iwt_pkg::REG_HEIGHT)) begin
			ref_pend_q <= 1'b1;
		end else if (ref_clr) begin
			ref_pend_q <= 1'b0;
		end
	end

	// read back
	always_comb begin
		case (idx)
			iwt_pkg::REG_CLOSE:  prdata = {16'd0, cfg_q.close_ms};
			iwt_pkg::REG_HOLD:   prdata = {16'd0, cfg_q.hold_ms};
			iwt_pkg::REG_OPEN:   prdata = {16'd0, cfg_q.open_ms};
			iwt_pkg::REG_LEVELS: prdata = {24'd0, cfg_q.num_levels};
			iwt_pkg::REG_WIDTH:  prdata = {21'd0, cfg_q.frame_width};
			iwt_pkg::REG_HEIGHT: prdata = {21'd0, cfg_q.frame_height};
			default:             prdata = 32'd0;
		endcase
	end

	assign cfg      = cfg_q;
	assign ref_pend = ref_pend_q;

endmodule

[src/iwt_ctrl.sv]
// Sequencing state machine of the iris wipe transition.
module iwt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  logic          ref_pend,
	input  iwt_pkg::sts_t sts,
	output iwt_pkg::cmd_t cmd
);

	iwt_pkg::ctrl_state_t state_q, state_d;
	logic                 item_ref_q, item_ref_d;
	logic                 rsp_valid_q;
	logic                 slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= iwt_pkg::ST_IDLE;
			item_ref_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			item_ref_q <= item_ref_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		item_ref_d = item_ref_q;
		cmd        = '0;
		req_stall  = 1'b1;
		case (state_q)
			iwt_pkg::ST_IDLE: begin
				if (ref_pend) begin
					cmd.ref_clr = 1'b1;
					item_ref_d  = 1'b0;
					state_d     = iwt_pkg::ST_REF_SQ;
				end else begin
					req_stall = 1'b0;
					if (req_valid) begin
						cmd.capture = 1'b1;
						state_d     = iwt_pkg::ST_EXEC;
					end
				end
			end
			iwt_pkg::ST_EXEC: begin
				cmd.exec   = 1'b1;
				item_ref_d = 1'b1;
				if (sts.need_div) begin
					state_d = iwt_pkg::ST_DIV;
				end else if (sts.need_ref) begin
					state_d = iwt_pkg::ST_REF_SQ;
				end else begin
					state_d = iwt_pkg::ST_EMIT;
				end
			end
			iwt_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = iwt_pkg::ST_REF_SQ;
				end
			end
			iwt_pkg::ST_REF_SQ: begin
				cmd.ref_sq = 1'b1;
				state_d    = iwt_pkg::ST_REF_DIAG;
			end
			iwt_pkg::ST_REF_DIAG: begin
				cmd.ref_diag = 1'b1;
				state_d      = iwt_pkg::ST_REF_LO;
			end
			iwt_pkg::ST_REF_LO: begin
				cmd.ref_lo = 1'b1;
				state_d    = iwt_pkg::ST_REF_HI;
			end
			iwt_pkg::ST_REF_HI: begin
				cmd.ref_hi = 1'b1;
				state_d    = iwt_pkg::ST_REF_SUM;
			end
			iwt_pkg::ST_REF_SUM: begin
				cmd.ref_sum = 1'b1;
				state_d     = item_ref_q ? iwt_pkg::ST_EMIT : iwt_pkg::ST_IDLE;
			end
			iwt_pkg::ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = iwt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iwt_pkg::ST_IDLE;
			end
		endcase
	end

	// output register valid: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[src/iwt_dp.sv]
// Datapath of the iris wipe transition: state, radius divider, limit and pixel mask.
module iwt_dp #(
	parameter int MAX_DIM_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  iwt_pkg::cmd_t cmd,
	input  iwt_pkg::cfg_t cfg,
	input  iwt_pkg::in_t  req_data,
	output iwt_pkg::sts_t sts,
	output iwt_pkg::out_t rsp_data
);

	localparam int M         = MAX_DIM_BITS;
	localparam int DIM_W     = M + 1;
	localparam int EW        = (DIM_W > 11) ? DIM_W : 11;
	localparam int XW        = (M > 10) ? M : 10;
	localparam int DIAG_W    = 2 * M + 2;
	localparam int DX_W      = M + 3;
	localparam int SQ_W      = 2 * M + 2;
	localparam int AW        = DIAG_W + 17;
	localparam int HW        = DIAG_W + 16;
	localparam int FW        = DIAG_W + 33;
	localparam int DIV_CNT_W = iwt_pkg::DIV_CNT_W;

	// transition state
	logic              running_q;
	logic [1:0]        phase_q;
	logic [15:0]       elapsed_q;
	logic [16:0]       radius_q;
	logic [DIAG_W-1:0] limit_q;
	logic [7:0]        tlvl_q;
	logic              trst_q;
	logic              loaded_q;

	// request and result holding
	iwt_pkg::in_t      item_q;
	logic              res_req_q;
	logic [7:0]        res_lvl_q;
	logic              res_rst_q;
	iwt_pkg::out_t     rsp_q;

	// next-state values from the request
	logic              n_running;
	logic [1:0]        n_phase;
	logic [15:0]       n_elapsed;
	logic [16:0]       n_radius;
	logic [7:0]        n_tlvl;
	logic              n_trst;
	logic              n_loaded;
	logic              n_req;
	logic [7:0]        n_lvl;
	logic              n_rst;
	logic              need_div;
	logic              need_ref;
	logic              div_open;
	logic [16:0]       t_sum;
	logic [15:0]       t_sat;

	// divider
	logic [15:0]          div_rem_q;
	logic [15:0]          div_quo_q;
	logic [15:0]          div_den_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [16:0]          rem2;
	logic                 div_ge;
	logic [16:0]          rem_nx;
	logic [15:0]          quo_nx;

	// limit refresh
	logic [EW-1:0]     fw_x, fh_x, cap_x;
	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [33:0]       rr_full;
	logic [32:0]       rr_q;
	logic [DIAG_W-1:0] ww_q, hh_q, diag_q;
	logic [AW-1:0]     acc_q;
	logic [HW-1:0]     hi_q;
	logic [FW-1:0]     full_sum;

	// pixel distance
	logic [XW-1:0]          xw, yw;
	logic [M-1:0]           xm, ym;
	logic signed [DX_W-1:0] dx, dy;
	logic [2*DX_W-1:0]      dxx, dyy;
	logic [SQ_W-1:0]        sq_x_q, sq_y_q;
	logic [SQ_W:0]          dist_sq;
	logic [31:0]            pix;

	// saturating timer sum
	assign t_sum = {1'b0, elapsed_q} + {7'd0, item_q.delta_ms};
	assign t_sat = t_sum[16] ? 16'hFFFF : t_sum[15:0];

	// decide the update for one request
	always_comb begin
		n_running = running_q;
		n_phase   = phase_q;
		n_elapsed = elapsed_q;
		n_radius  = radius_q;
		n_tlvl    = tlvl_q;
		n_trst    = trst_q;
		n_loaded  = loaded_q;
		n_req     = 1'b0;
		n_lvl     = 8'd0;
		n_rst     = 1'b0;
		need_div  = 1'b0;
		need_ref  = 1'b0;
		div_open  = 1'b0;
		case (item_q.kind)
			iwt_pkg::KIND_START: begin
				if (item_q.level_index >= cfg.num_levels) begin
					// invalid level: load directly
					n_req = 1'b1;
					n_lvl = item_q.level_index;
					n_rst = item_q.reset_player;
				end else if (!running_q) begin
					n_running = 1'b1;
					n_phase   = iwt_pkg::PH_CLOSE;
					n_elapsed = 16'd0;
					n_radius  = iwt_pkg::RADIUS_FULL;
					n_tlvl    = item_q.level_index;
					n_trst    = item_q.reset_player;
					n_loaded  = 1'b0;
					need_ref  = 1'b1;
				end
			end
			iwt_pkg::KIND_LOAD: begin
				if (running_q && phase_q == iwt_pkg::PH_HOLD && item_q.load_ok) begin
					n_loaded = 1'b1;
				end
			end
			iwt_pkg::KIND_TICK: begin
				if (running_q) begin
					need_ref = 1'b1;
					case (phase_q)
						iwt_pkg::PH_CLOSE: begin
							if (t_sat >= cfg.close_ms) begin
								n_radius  = 17'd0;
								n_req     = !loaded_q;
								n_lvl     = loaded_q ? 8'd0 : tlvl_q;
								n_rst     = !loaded_q && trst_q;
								n_phase   = iwt_pkg::PH_HOLD;
								n_elapsed = 16'd0;
							end else begin
								n_elapsed = t_sat;
								need_div  = 1'b1;
							end
						end
						iwt_pkg::PH_HOLD: begin
							n_req    = !loaded_q;
							n_lvl    = loaded_q ? 8'd0 : tlvl_q;
							n_rst    = !loaded_q && trst_q;
							n_radius = 17'd0;
							if (t_sat >= cfg.hold_ms) begin
								n_phase   = iwt_pkg::PH_OPEN;
								n_elapsed = 16'd0;
							end else begin
								n_elapsed = t_sat;
							end
						end
						iwt_pkg::PH_OPEN: begin
							if (t_sat >= cfg.open_ms) begin
								n_running = 1'b0;
								n_phase   = iwt_pkg::PH_CLOSE;
								n_elapsed = 16'd0;
								n_loaded  = 1'b0;
								n_radius  = iwt_pkg::RADIUS_FULL;
							end else begin
								n_elapsed = t_sat;
								need_div  = 1'b1;
								div_open  = 1'b1;
							end
						end
						default: begin
							// unused phase: finish the transition
							n_running = 1'b0;
							n_phase   = iwt_pkg::PH_CLOSE;
							n_elapsed = 16'd0;
							n_loaded  = 1'b0;
							n_radius  = iwt_pkg::RADIUS_FULL;
						end
					endcase
				end
			end
			iwt_pkg::KIND_PIXEL: ;
			default: ;
		endcase
	end

	// one restoring division step
	assign rem2   = {div_rem_q, 1'b0};
	assign div_ge = rem2 >= {1'b0, div_den_q};
	assign rem_nx = div_ge ? rem2 - {1'b0, div_den_q} : rem2;
	assign quo_nx = {div_quo_q[iwt_pkg::DIV_STEPS-2:0], div_ge};

	// transition state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			phase_q   <= iwt_pkg::PH_CLOSE;
			elapsed_q <= 16'd0;
			radius_q  <= iwt_pkg::RADIUS_FULL;
			limit_q   <= '0;
			tlvl_q    <= 8'd0;
			trst_q    <= 1'b1;
			loaded_q  <= 1'b0;
		end else begin
			if (cmd.exec) begin
				running_q <= n_running;
				phase_q   <= n_phase;
				elapsed_q <= n_elapsed;
				radius_q  <= n_radius;
				tlvl_q    <= n_tlvl;
				trst_q    <= n_trst;
				loaded_q  <= n_loaded;
			end else if (cmd.div_step && div_cnt_q == '0) begin
				radius_q <= (phase_q == iwt_pkg::PH_CLOSE) ?
					iwt_pkg::RADIUS_FULL - {1'b0, quo_nx} : {1'b0, quo_nx};
			end
			if (cmd.ref_sum) begin
				limit_q <= full_sum[32 +: DIAG_W];
			end
		end
	end

	// capture request, hold result fields, run divider
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req_data;
		end
		if (cmd.exec) begin
			res_req_q <= n_req;
			res_lvl_q <= n_lvl;
			res_rst_q <= n_rst;
			div_rem_q <= t_sat;
			div_quo_q <= 16'd0;
			div_den_q <= div_open ? cfg.open_ms : cfg.close_ms;
			div_cnt_q <= DIV_CNT_W'(iwt_pkg::DIV_STEPS - 1);
			sq_x_q    <= dxx[SQ_W-1:0];
			sq_y_q    <= dyy[SQ_W-1:0];
		end else if (cmd.div_step) begin
			div_rem_q <= rem_nx[15:0];
			div_quo_q <= quo_nx;
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// effective frame size, saturated to the largest dimension
	assign fw_x  = EW'(cfg.frame_width);
	assign fh_x  = EW'(cfg.frame_height);
	assign cap_x = EW'(1) << M;
	assign w_eff = DIM_W'((fw_x > cap_x) ? cap_x : fw_x);
	assign h_eff = DIM_W'((fh_x > cap_x) ? cap_x : fh_x);

	// limit = (w*w + h*h) * r * r >> 32, in partial products
	assign rr_full  = 34'(radius_q) * 34'(radius_q);
	assign full_sum = FW'(acc_q) + (FW'(hi_q) << 17);

	always_ff @(posedge clk) begin
		if (cmd.ref_sq) begin
			rr_q <= rr_full[32:0];
			ww_q <= DIAG_W'(w_eff) * DIAG_W'(w_eff);
			hh_q <= DIAG_W'(h_eff) * DIAG_W'(h_eff);
		end
		if (cmd.ref_diag) begin
			diag_q <= ww_q + hh_q;
		end
		if (cmd.ref_lo) begin
			acc_q <= AW'(diag_q) * AW'(rr_q[16:0]);
		end
		if (cmd.ref_hi) begin
			hi_q <= HW'(diag_q) * HW'(rr_q[32:17]);
		end
	end

	// half-pixel offsets from the frame centre
	assign xw  = XW'(item_q.pixel_x);
	assign yw  = XW'(item_q.pixel_y);
	assign xm  = xw[M-1:0];
	assign ym  = yw[M-1:0];
	assign dx  = $signed(DX_W'({xm, 1'b1}) - DX_W'(w_eff));
	assign dy  = $signed(DX_W'({ym, 1'b1}) - DX_W'(h_eff));
	assign dxx = dx * dx;
	assign dyy = dy * dy;

	// mask the pixel against the circle
	assign dist_sq = (SQ_W + 1)'(sq_x_q) + (SQ_W + 1)'(sq_y_q);

	always_comb begin
		if (item_q.kind != iwt_pkg::KIND_PIXEL) begin
			pix = 32'd0;
		end else if (!running_q || radius_q >= iwt_pkg::RADIUS_PASS) begin
			pix = item_q.pixel_color;
		end else if (radius_q <= iwt_pkg::RADIUS_BLACK) begin
			pix = iwt_pkg::BLACK_ARGB;
		end else if (dist_sq > (SQ_W + 1)'(limit_q)) begin
			pix = iwt_pkg::BLACK_ARGB;
		end else begin
			pix = item_q.pixel_color;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.pixel_out       <= pix;
			rsp_q.load_request    <= res_req_q;
			rsp_q.load_level      <= res_lvl_q;
			rsp_q.load_full_reset <= res_rst_q;
			rsp_q.busy_res        <= running_q;
			rsp_q.cur_phase       <= phase_q;
			rsp_q.cur_radius      <= radius_q;
		end
	end

	assign rsp_data     = rsp_q;
	assign sts.need_div = need_div;
	assign sts.need_ref = need_ref;
	assign sts.div_last = (div_cnt_q == '0);

endmodule

[src/iris_wipe_transition_top.sv]
// Top level of the iris wipe transition: registers, controller and datapath.
//
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | iwt_pkg::in_t
// rsp     | out       | rsp_valid / rsp_stall | iwt_pkg::out_t
// cfg     | in        | APB, always ready     | six registers at byte address 4*i
//
// Pixel, load result, idle tick and rejected start: capture, execute, then emit the result.
// Start that arms and tick in hold or at a phase end: capture, execute, 5-step limit refresh, emit.
// Tick that stays in closing or opening: capture, execute, 16-step radius divider, limit refresh, emit.
// A frame size write blocks requests while the limit is refreshed.
// Reset puts every state register at its listed value; there is no clearing pass.
// A finished result waits in the output register while the next request is taken.
module iris_wipe_transition_top #(
	parameter int MAX_DIM_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  iwt_pkg::in_t                req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output iwt_pkg::out_t               rsp_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [iwt_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

`include "iris_wipe_transition_top_defines.svh"

	iwt_pkg::cfg_t cfg;
	iwt_pkg::cmd_t cmd;
	iwt_pkg::sts_t sts;
	logic          ref_pend;

	// configuration registers
	iwt_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.ref_clr  (cmd.ref_clr),
		.cfg      (cfg),
		.ref_pend (ref_pend)
	);

	// sequencing
	iwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ref_pend  (ref_pend),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	iwt_dp #(
		.MAX_DIM_BITS (MAX_DIM_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.req_data (req_data),
		.sts      (sts),
		.rsp_data (rsp_data)
	);

	// an accepted request is executed in the next cycle
	`IWT_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, cmd.exec, "request not executed")

	// an idle result shows the closing phase at full radius
	`IWT_ASSERT_SAME(a_idle_result, rsp_valid && !rsp_data.busy_res, rsp_data.cur_phase == iwt_pkg::PH_CLOSE && rsp_data.cur_radius == iwt_pkg::RADIUS_FULL, "idle result with stale phase or radius")

	// the radius never exceeds full scale
	`IWT_ASSERT_SAME(a_radius_range, rsp_valid, rsp_data.cur_radius <= iwt_pkg::RADIUS_FULL, "radius above full scale")

endmodule
